/* rtl/np_pkg.sv */
// ----------------------------------------------------------------------------
// np_pkg: shared types and constants of the next-permutation block
// Element and length widths, the vector type and index widths used by the
// datapath and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package np_pkg;

	// vector geometry, fixed by the port list
	localparam int MAX_ELEMS = 10;
	localparam int ELEM_BITS = 4;
	localparam int LEN_BITS  = 4;
	localparam int IDX_BITS  = $clog2(MAX_ELEMS);
	// wide enough for an index plus a length
	localparam int SUM_BITS  = ((IDX_BITS > LEN_BITS) ? IDX_BITS : LEN_BITS) + 1;

	typedef logic [ELEM_BITS-1:0] elem_t;
	typedef elem_t [MAX_ELEMS-1:0] vec_t;
	typedef logic [LEN_BITS-1:0]  len_t;
	typedef logic [IDX_BITS-1:0]  idx_t;
	typedef logic [SUM_BITS-1:0]  sum_t;

endpackage

`default_nettype wire

/* rtl/np_core.sv */
// ----------------------------------------------------------------------------
// np_core: next lexicographic permutation datapath
// Finds the rightmost rise, swaps the pivot with the rightmost larger tail
// element and reverses the tail, all in one pass of combinational logic.
// ----------------------------------------------------------------------------
`default_nettype none

module np_core (
	input  wire np_pkg::len_t length,
	input  wire np_pkg::vec_t vec,
	output logic              no_next,
	output np_pkg::vec_t      res
);

	np_pkg::len_t  n_len;
	logic          found;
	np_pkg::idx_t  pos;      // index of the rightmost rise (pivot + 1)
	np_pkg::idx_t  piv_idx;
	np_pkg::elem_t pivot;
	np_pkg::idx_t  succ_idx;
	np_pkg::elem_t succ;
	np_pkg::sum_t  tsum;     // mirror sum: tail index m maps to tsum - m

	// clamp the length to the vector size
	always_comb begin
		if (length > np_pkg::len_t'(np_pkg::MAX_ELEMS)) begin
			n_len = np_pkg::len_t'(np_pkg::MAX_ELEMS);
		end else begin
			n_len = length;
		end
	end

	// rightmost rise inside the valid part
	always_comb begin
		found = 1'b0;
		pos   = '0;
		for (int i = 1; i < np_pkg::MAX_ELEMS; i++) begin
			if ((np_pkg::len_t'(i) < n_len) && (vec[i] > vec[i-1])) begin
				found = 1'b1;
				pos   = np_pkg::idx_t'(i);
			end
		end
	end

	assign piv_idx = pos - 1'b1;

	// pivot value
	always_comb begin
		pivot = '0;
		for (int j = 0; j < np_pkg::MAX_ELEMS; j++) begin
			if (np_pkg::idx_t'(j) == piv_idx) begin
				pivot = vec[j];
			end
		end
	end

	// tail is non-increasing: the rightmost element above the pivot is the
	// smallest larger value, and swapping there keeps the tail ordered
	always_comb begin
		succ_idx = pos;
		succ     = '0;
		for (int j = 0; j < np_pkg::MAX_ELEMS; j++) begin
			if ((np_pkg::idx_t'(j) >= pos) && (np_pkg::len_t'(j) < n_len) &&
			    (vec[j] > pivot)) begin
				succ_idx = np_pkg::idx_t'(j);
				succ     = vec[j];
			end
		end
	end

	assign tsum = np_pkg::sum_t'(pos) + np_pkg::sum_t'(n_len) - 1'b1;

	// swap pivot, reverse the tail, pass everything else through
	always_comb begin
		res = vec;
		if (found) begin
			for (int m = 0; m < np_pkg::MAX_ELEMS; m++) begin
				if (np_pkg::idx_t'(m) == piv_idx) begin
					res[m] = succ;
				end else if ((np_pkg::idx_t'(m) >= pos) &&
				             (np_pkg::len_t'(m) < n_len)) begin
					for (int j = 0; j < np_pkg::MAX_ELEMS; j++) begin
						if ((np_pkg::sum_t'(j) + np_pkg::sum_t'(m)) == tsum) begin
							res[m] = (np_pkg::idx_t'(j) == succ_idx) ? pivot : vec[j];
						end
					end
				end
			end
		end
	end

	assign no_next = ~found;

endmodule

`default_nettype wire

/* rtl/next_permutation.sv */
// ----------------------------------------------------------------------------
// next_permutation: next lexicographic permutation of a ten-element vector
// Top level with input register, datapath and output register.
// ----------------------------------------------------------------------------
// One transfer in, one transfer out. A vector is accepted every cycle as long
// as the output side keeps taking results. The result of a vector is computed
// from the input register and offered from the output register, where it
// waits while the output side stalls. The input and output registers form
// a two-entry pipeline. The single pass of the compare, swap and reverse
// logic between them sets the one-cycle rate.
// Lengths above ten count as ten. A length below two or a non-rising vector
// returns the elements unchanged with no_next set.
`default_nettype none

module next_permutation (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_stall,
	input  wire np_pkg::len_t  length,
	input  wire np_pkg::elem_t elem_0,
	input  wire np_pkg::elem_t elem_1,
	input  wire np_pkg::elem_t elem_2,
	input  wire np_pkg::elem_t elem_3,
	input  wire np_pkg::elem_t elem_4,
	input  wire np_pkg::elem_t elem_5,
	input  wire np_pkg::elem_t elem_6,
	input  wire np_pkg::elem_t elem_7,
	input  wire np_pkg::elem_t elem_8,
	input  wire np_pkg::elem_t elem_9,
	output logic               out_valid,
	input  wire                out_stall,
	output logic               no_next,
	output np_pkg::elem_t      out_0,
	output np_pkg::elem_t      out_1,
	output np_pkg::elem_t      out_2,
	output np_pkg::elem_t      out_3,
	output np_pkg::elem_t      out_4,
	output np_pkg::elem_t      out_5,
	output np_pkg::elem_t      out_6,
	output np_pkg::elem_t      out_7,
	output np_pkg::elem_t      out_8,
	output np_pkg::elem_t      out_9
);

	logic         valid_s1;
	np_pkg::len_t length_s1;
	np_pkg::vec_t vec_s1;
	logic         valid_s2;
	logic         no_next_s2;
	np_pkg::vec_t vec_s2;
	np_pkg::vec_t res;
	logic         res_no_next;
	logic         adv_s1;
	logic         adv_s2;

	// pipeline flow control
	assign adv_s2   = ~valid_s2 | ~out_stall;
	assign adv_s1   = ~valid_s1 | adv_s2;
	assign in_stall = ~adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			length_s1 <= length;
			vec_s1    <= {elem_9, elem_8, elem_7, elem_6, elem_5,
			              elem_4, elem_3, elem_2, elem_1, elem_0};
		end
	end

	np_core u_core (
		.length  (length_s1),
		.vec     (vec_s1),
		.no_next (res_no_next),
		.res     (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			no_next_s2 <= res_no_next;
			vec_s2     <= res;
		end
	end

	assign out_valid = valid_s2;
	assign no_next   = no_next_s2;
	assign out_0     = vec_s2[0];
	assign out_1     = vec_s2[1];
	assign out_2     = vec_s2[2];
	assign out_3     = vec_s2[3];
	assign out_4     = vec_s2[4];
	assign out_5     = vec_s2[5];
	assign out_6     = vec_s2[6];
	assign out_7     = vec_s2[7];
	assign out_8     = vec_s2[8];
	assign out_9     = vec_s2[9];

endmodule

`default_nettype wire

/* rtl/np_check.sv */
// ----------------------------------------------------------------------------
// np_check: port-level checks of the next-permutation block
// Watches the handshakes and one end-to-end property; bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module np_check (
	input wire                clk,
	input wire                arst_n,
	input wire                in_valid,
	input wire                in_stall,
	input wire np_pkg::len_t  length,
	input wire                out_valid,
	input wire                out_stall,
	input wire                no_next,
	input wire np_pkg::elem_t out_0,
	input wire np_pkg::elem_t out_9
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(no_next) && $stable(out_0) && $stable(out_9))
		else $error("stalled result changed");

	// with the output side empty the input never stalls
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	// a short vector comes back flagged when the output side does not stall after its transfer
	a_short_len: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (length == 4'd0 || length == 4'd1) ##1 !out_stall
		|=> out_valid && no_next)
		else $error("short vector not flagged");

endmodule

bind next_permutation np_check u_check (.*);

`default_nettype wire

/* tb/next_permutation_test.sv */
// ----------------------------------------------------------------------------
// next_permutation_test: self-checking bench for the next-permutation block
// Feeds directed corner vectors and about a thousand random ones: walks
// through successive permutations, non-rising vectors, short and oversized
// lengths. Both handshake sides idle at random, and the output side holds off
// once for a long stretch. Every result transfer is checked field by field
// against a successor computed in the bench.
// ----------------------------------------------------------------------------
`default_nettype none

package perm_check_pkg;

	import np_pkg::*;

	typedef struct packed {
		logic no_next;
		vec_t elems;
	} succ_t;

	// next arrangement in lexicographic order, position 0 most significant
	function automatic succ_t lex_successor(len_t len, vec_t v);
		succ_t  r;
		int     n, rise, j, pick, p, q;
		elem_t  pivot, key;
		r.no_next = 1'b1;
		n = (len > MAX_ELEMS) ? MAX_ELEMS : int'(len);
		if (n >= 2) begin
			// rightmost position whose element exceeds its left neighbor
			rise = n - 1;
			while (rise > 0 && v[rise] <= v[rise-1])
				rise--;
			if (rise > 0) begin
				r.no_next = 1'b0;
				pivot = v[rise-1];
				pick = rise;
				// smallest larger element to the right, leftmost on ties
				for (j = rise + 1; j < n; j++)
					if (v[j] > pivot && v[j] < v[pick])
						pick = j;
				v[rise-1] = v[pick];
				v[pick] = pivot;
				// tail back into ascending order
				for (p = rise + 1; p < n; p++) begin
					key = v[p];
					q = p - 1;
					while (q >= rise && v[q] > key) begin
						v[q+1] = v[q];
						q--;
					end
					v[q+1] = key;
				end
			end
		end
		r.elems = v;
		return r;
	endfunction

	class successor_board;
		succ_t awaited[$];
		int    mismatches;
		int    seen;

		function new();
			mismatches = 0;
			seen = 0;
		endfunction

		task report(string what);
			if (mismatches < 50)
				$display("ERROR result %0d: %s", seen, what);
			mismatches++;
		endtask

		function int pending();
			return awaited.size();
		endfunction

		// input transfer accepted: queue the successor it must produce
		function void note_vector(len_t len, vec_t v);
			awaited.push_back(lex_successor(len, v));
		endfunction

		// output transfer accepted: compare with the oldest successor
		task check_result(logic flag, vec_t got);
			succ_t want;
			seen++;
			if (awaited.size() == 0) begin
				report("result transfer with no vector awaiting it");
				return;
			end
			want = awaited.pop_front();
			if (flag !== want.no_next)
				report($sformatf("no_next got %b want %b", flag, want.no_next));
			for (int i = 0; i < MAX_ELEMS; i++)
				if (got[i] !== want.elems[i])
					report($sformatf("out_%0d got %0d want %0d", i, got[i], want.elems[i]));
		endtask
	endclass

endpackage

module next_permutation_test;

	timeunit 1ns;
	timeprecision 1ps;

	import np_pkg::*;
	import perm_check_pkg::*;

	localparam int RANDOM_ITEMS = 950;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 64;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	len_t length = '0;
	vec_t tx_vec = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic no_next;
	wire vec_t rx_vec;

	// set by the output side during its long hold-off
	logic hold_off = 1'b0;
	int   cycles = 0;

	successor_board sb;

	next_permutation dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.length    (length),
		.elem_0    (tx_vec[0]),
		.elem_1    (tx_vec[1]),
		.elem_2    (tx_vec[2]),
		.elem_3    (tx_vec[3]),
		.elem_4    (tx_vec[4]),
		.elem_5    (tx_vec[5]),
		.elem_6    (tx_vec[6]),
		.elem_7    (tx_vec[7]),
		.elem_8    (tx_vec[8]),
		.elem_9    (tx_vec[9]),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.no_next   (no_next),
		.out_0     (rx_vec[0]),
		.out_1     (rx_vec[1]),
		.out_2     (rx_vec[2]),
		.out_3     (rx_vec[3]),
		.out_4     (rx_vec[4]),
		.out_5     (rx_vec[5]),
		.out_6     (rx_vec[6]),
		.out_7     (rx_vec[7]),
		.out_8     (rx_vec[8]),
		.out_9     (rx_vec[9])
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// offer one vector and hold it until the transfer
	task automatic send_vector(len_t len, vec_t v);
		in_valid <= 1'b1;
		length <= len;
		tx_vec <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_vector(len, v);
	endtask

	function automatic vec_t random_vec(int top);
		vec_t v;
		for (int i = 0; i < MAX_ELEMS; i++)
			v[i] = elem_t'($urandom_range(top, 0));
		return v;
	endfunction

	function automatic len_t random_len();
		if ($urandom_range(7, 0) == 0)
			return len_t'($urandom_range(15, MAX_ELEMS + 1));
		return len_t'($urandom_range(MAX_ELEMS, 0));
	endfunction

	// output side: stall patterns in segments, one long hold-off early on
	initial begin
		int mode, seg_len, segs;
		logic s;
		segs = 0;
		while (!arst_n)
			@(posedge clk);
		forever begin
			segs++;
			if (segs == 3) begin
				hold_off <= 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off <= 1'b0;
			end
			mode = $urandom_range(4, 0);
			seg_len = $urandom_range(200, 20);
			for (int k = 0; k < seg_len; k++) begin
				case (mode)
					0: s = 1'b0;
					1: s = ($urandom_range(3, 0) == 0);
					2: s = ($urandom_range(3, 0) != 0);
					3: s = k[0];
					default: s = ((k % 5) < 2);
				endcase
				out_stall <= s;
				@(posedge clk);
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(no_next, rx_vec);
	end

	// watchdog
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL next_permutation");
		$finish;
	end

	// reset, stimulus, drain, verdict
	initial begin
		int    sent, burst, gap, r, n;
		len_t  len, walk_len;
		vec_t  v, walk_vec;
		elem_t t;
		logic  walk_live;
		succ_t nxt;
		sb = new();
		walk_live = 1'b0;
		walk_len = '0;
		walk_vec = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed corners; position 0 is the low nibble of each literal
		send_vector(4'd0, 40'h0123456789);   // empty
		send_vector(4'd1, 40'h9876543210);   // single element
		send_vector(4'd2, 40'h3333333321);   // two rising
		send_vector(4'd2, 40'h3333333312);   // two falling
		send_vector(4'd10, 40'h9876543210);  // first permutation
		send_vector(4'd10, 40'h0123456789);  // last permutation
		send_vector(4'd10, 40'h1023456789);  // one before last
		send_vector(4'd10, 40'hFFFFFFFFFF);  // all max
		send_vector(4'd10, 40'h0000000000);  // all zero
		send_vector(4'd10, 40'hFFFFFFFFF0);  // rise at the front
		send_vector(4'd4, 40'hABCDEF2231);   // tie on the swap partner
		send_vector(4'd4, 40'h5555552211);   // duplicates
		send_vector(4'd3, 40'h7777777231);   // pivot at the front of three
		send_vector(4'd5, 40'hFFFFF01234);   // non-rising, tail passes through
		send_vector(4'd15, 40'h9876543210);  // oversized length
		send_vector(4'd11, 40'h0123456789);  // oversized, non-rising
		send_vector(4'd12, 40'hFEDCBA9876);
		send_vector(4'd14, 40'h3141592653);
		send_vector(4'd10, 40'hF0F0F0F0F0);
		send_vector(4'd8, 40'h5A5A5A5A5A);
		send_vector(4'd9, 40'hA5A5A5A5A5);
		send_vector(4'd7, 40'h00000000F0);

		// random bursts
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(40, 1);
			for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
				r = $urandom_range(9, 0);
				if (r < 5) begin
					// walk through successive permutations
					if (!walk_live) begin
						walk_len = len_t'($urandom_range(MAX_ELEMS, 2));
						walk_vec = random_vec($urandom_range(1, 0) ? 3 : 15);
						walk_live = 1'b1;
					end
					len = walk_len;
					v = walk_vec;
					nxt = lex_successor(len, v);
					walk_vec = nxt.elems;
					walk_live = !nxt.no_next && ($urandom_range(40, 0) != 0);
				end else if (r < 8) begin
					len = random_len();
					v = random_vec((r == 5) ? 3 : 15);
				end else if (r == 8) begin
					// non-rising vector, sometimes with one adjacent pair swapped
					len = random_len();
					v = random_vec(15);
					n = (len > MAX_ELEMS) ? MAX_ELEMS : int'(len);
					for (int i = 0; i < n; i++)
						for (int j = 0; j + 1 < n - i; j++)
							if (v[j] < v[j+1]) begin
								t = v[j];
								v[j] = v[j+1];
								v[j+1] = t;
							end
					if (n >= 2 && $urandom_range(1, 0)) begin
						r = $urandom_range(n - 2, 0);
						t = v[r];
						v[r] = v[r+1];
						v[r+1] = t;
					end
				end else begin
					// short or oversized length
					len = $urandom_range(1, 0) ? len_t'($urandom_range(2, 0))
					                           : len_t'($urandom_range(15, MAX_ELEMS + 1));
					v = random_vec(15);
				end
				send_vector(len, v);
				sent++;
			end
			gap = (hold_off || $urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b0;

		// drain, then give stray results a chance to show
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0)
			$display("PASS next_permutation");
		else
			$display("FAIL next_permutation");
		$finish;
	end

endmodule

`default_nettype wire
